// ----- rtl/mpm_pkg.sv -----
package mpm_pkg;

    localparam int CountW  = 32;
    localparam int PeriodW = 16;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_SYNC_LOW  = 3'd1;
    localparam logic [2:0] PH_SYNC_HIGH = 3'd2;
    localparam logic [2:0] PH_MEAS_LOW  = 3'd3;
    localparam logic [2:0] PH_MEAS_HIGH = 3'd4;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic CFG_NUM_PERIODS = 1'b0;
    localparam logic CFG_TIMEOUT     = 1'b1;

    localparam logic [PeriodW-1:0] NUM_PERIODS_RESET = 16'd100;
    localparam logic [CountW-1:0]  TIMEOUT_RESET     = 32'd10000000;

    typedef struct packed {
        logic kind;
        logic pin_level;
    } item_t;

    typedef struct packed {
        logic [PeriodW-1:0] num_periods;
        logic [CountW-1:0]  timeout_ticks;
    } cfg_t;

endpackage

// ----- rtl/mpm_cfg.sv -----
module mpm_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [mpm_pkg::CountW-1:0] cfg_data,
    output mpm_pkg::cfg_t             cfg
);

    logic [mpm_pkg::PeriodW-1:0] num_periods_reg;
    logic [mpm_pkg::CountW-1:0]  timeout_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_periods_reg   <= mpm_pkg::NUM_PERIODS_RESET;
            timeout_ticks_reg <= mpm_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mpm_pkg::CFG_NUM_PERIODS: num_periods_reg <= cfg_data[mpm_pkg::PeriodW-1:0];
                mpm_pkg::CFG_TIMEOUT:     timeout_ticks_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    assign cfg.num_periods   = num_periods_reg;
    assign cfg.timeout_ticks = timeout_ticks_reg;

endmodule

// ----- rtl/mpm_in_stage.sv -----
module mpm_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           kind,
    input  logic           pin_level,
    input  logic           take,
    output logic           item_valid,
    output mpm_pkg::item_t item
);

    logic           valid_reg;
    mpm_pkg::item_t item_reg;

    assign in_ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.kind      <= kind;
            item_reg.pin_level <= pin_level;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/mpm_core.sv -----
module mpm_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  mpm_pkg::item_t             item,
    output logic                       take,
    input  mpm_pkg::cfg_t              cfg,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [mpm_pkg::CountW-1:0] period_count,
    output logic                       timed_out
);

    logic [2:0]                  phase_reg, phase_next;
    logic [mpm_pkg::CountW-1:0]  tick_counter_reg, tick_counter_next;
    logic [mpm_pkg::PeriodW-1:0] periods_done_reg, periods_done_next;
    logic                        out_valid_reg;
    logic [mpm_pkg::CountW-1:0]  period_count_reg;
    logic                        timed_out_reg;

    logic [mpm_pkg::CountW-1:0]  count_inc;
    logic [mpm_pkg::PeriodW-1:0] periods_inc;
    logic                        want_high;
    logic                        met;
    logic                        emit;
    logic [mpm_pkg::CountW-1:0]  emit_count;
    logic                        emit_flag;

    assign take = item_valid && (!out_valid_reg || out_ready);

    assign count_inc   = (tick_counter_reg == '1) ? tick_counter_reg
                                                  : tick_counter_reg + 1'b1;
    assign periods_inc = periods_done_reg + 1'b1;
    assign want_high   = (phase_reg == mpm_pkg::PH_SYNC_HIGH) ||
                         (phase_reg == mpm_pkg::PH_MEAS_HIGH);
    assign met         = want_high ? item.pin_level : !item.pin_level;

    always_comb
    begin
        phase_next        = phase_reg;
        tick_counter_next = tick_counter_reg;
        periods_done_next = periods_done_reg;
        emit              = 1'b0;
        emit_count        = '0;
        emit_flag         = 1'b0;
        if (take)
        begin
            if (item.kind == mpm_pkg::KIND_START)
            begin
                phase_next        = mpm_pkg::PH_SYNC_LOW;
                tick_counter_next = '0;
                periods_done_next = '0;
            end
            else
            begin
                case (phase_reg)
                    mpm_pkg::PH_SYNC_LOW,
                    mpm_pkg::PH_SYNC_HIGH,
                    mpm_pkg::PH_MEAS_LOW,
                    mpm_pkg::PH_MEAS_HIGH:
                    begin
                        tick_counter_next = count_inc;
                        if (!met)
                        begin
                            if (count_inc > cfg.timeout_ticks)
                            begin
                                emit       = 1'b1;
                                emit_flag  = 1'b1;
                                phase_next = mpm_pkg::PH_IDLE;
                            end
                        end
                        else
                        begin
                            case (phase_reg)
                                mpm_pkg::PH_SYNC_LOW:
                                begin
                                    tick_counter_next = '0;
                                    phase_next        = mpm_pkg::PH_SYNC_HIGH;
                                end
                                mpm_pkg::PH_SYNC_HIGH:
                                begin
                                    tick_counter_next = '0;
                                    periods_done_next = '0;
                                    phase_next        = mpm_pkg::PH_MEAS_LOW;
                                end
                                mpm_pkg::PH_MEAS_LOW:
                                begin
                                    phase_next = mpm_pkg::PH_MEAS_HIGH;
                                end
                                default:
                                begin
                                    periods_done_next = periods_inc;
                                    if ((periods_inc >= cfg.num_periods) ||
                                        (periods_inc == '0))
                                    begin
                                        emit       = 1'b1;
                                        emit_count = count_inc;
                                        phase_next = mpm_pkg::PH_IDLE;
                                    end
                                    else
                                    begin
                                        phase_next = mpm_pkg::PH_MEAS_LOW;
                                    end
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        phase_next = mpm_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= mpm_pkg::PH_IDLE;
            tick_counter_reg <= '0;
            periods_done_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            tick_counter_reg <= tick_counter_next;
            periods_done_reg <= periods_done_next;
            if (take && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            period_count_reg <= emit_count;
            timed_out_reg    <= emit_flag;
        end
    end

    assign out_valid    = out_valid_reg;
    assign period_count = period_count_reg;
    assign timed_out    = timed_out_reg;

    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && timed_out_reg |-> period_count_reg == '0)
        else $error("timeout result with nonzero count");

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take && emit |=> phase_reg == mpm_pkg::PH_IDLE && out_valid_reg)
        else $error("result issued without returning to idle");

    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.kind == mpm_pkg::KIND_START |=>
        phase_reg == mpm_pkg::PH_SYNC_LOW && tick_counter_reg == '0 &&
        periods_done_reg == '0)
        else $error("start did not arm the meter");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        take && phase_reg == mpm_pkg::PH_IDLE |-> !emit)
        else $error("result produced while idle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !take)
        else $error("item processed while result is stalled");

endmodule

// ----- rtl/multi_period_meter.sv -----
// A result reaches the output after the tick transaction that completes the run:
// that transaction passes the input register, then the result is held in the result register.
// Throughput: one transaction per cycle while no result is stalled, set by the single-pass state update.
// An unaccepted result stalls input only while out_ready is low.
// Reset (rst_n low, asynchronous) returns the meter to idle, clears counters
// and loads num_periods = 100 and timeout_ticks = 10000000.
module multi_period_meter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    input  logic                       pin_level,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [mpm_pkg::CountW-1:0] period_count,
    output logic                       timed_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [mpm_pkg::CountW-1:0] cfg_data
);

    mpm_pkg::cfg_t  cfg;
    mpm_pkg::item_t item;
    logic           item_valid;
    logic           take;

    mpm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .pin_level  (pin_level),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    mpm_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .take         (take),
        .cfg          (cfg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .period_count (period_count),
        .timed_out    (timed_out)
    );

endmodule
